>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk and off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The condition holds at every edge out of reset.
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/tac_pkg.sv
// ---------------------------------------------------------------------------
// tac_pkg
// Widths, constants and shared types of the thermistor temperature pipeline.
// ---------------------------------------------------------------------------
package tac_pkg;

  // Converter resolution and field widths.
  localparam int ADC_BITS   = 12;
  localparam int CODE_W     = 12;
  localparam int IN_DATA_W  = 16;
  localparam int RES_W      = 20;
  localparam int BETA_W     = 16;
  localparam int T0_W       = 16;
  localparam int TEMP_W     = 18;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 2;

  // Full-scale code.
  localparam logic [ADC_BITS-1:0] FULL_CODE = {ADC_BITS{1'b1}};

  // Log stage widths: products of a resistor and a code, log2 in Q24.
  localparam int VAL_W    = RES_W + ADC_BITS;
  localparam int POS_W    = $clog2(VAL_W);
  localparam int MANT_W   = 32;
  localparam int LOG_FRAC = 24;
  localparam int LOG_W    = POS_W + LOG_FRAC;

  // ln(2) in Q30.
  localparam int          LN2_W   = 30;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam int          PROD_W  = LOG_W + LN2_W;
  localparam int          L_W     = LOG_W + 1;

  // Denominator and numerator of the Beta equation.
  localparam int TL_W   = T0_W + 1 + L_W;
  localparam int B100_W = 23;
  localparam int DENS_W = 49;
  localparam int DEN_W  = 48;
  localparam int NB_W   = 39;
  localparam int N_W    = 64;
  localparam int Q_W    = 18;

  // Temperature limits in hundredths of a degree.
  localparam int KELVIN_OFFSET = 27315;
  localparam int TEMP_MAX      = 100000;
  localparam int TCK_MAX       = 127315;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BETA      = 4'd0,
    REG_FIXED_RES = 4'd1,
    REG_NOM_RES   = 4'd2,
    REG_NOM_TEMP  = 4'd3
  } cfg_reg_t;

  localparam logic [BETA_W-1:0] BETA_RST      = 16'd3950;
  localparam logic [RES_W-1:0]  FIXED_RES_RST = 20'd10000;
  localparam logic [RES_W-1:0]  NOM_RES_RST   = 20'd10000;
  localparam logic [T0_W-1:0]   NOM_TEMP_RST  = 16'd29815;

  // Flags that travel with a word through the divider.
  typedef struct packed {
    logic skip;
    logic clip;
  } div_tag_t;

endpackage

>>> rtl/tac_log2.sv
// ---------------------------------------------------------------------------
// tac_log2
// Pipelined log2 in Q24: one normalize stage, then one squaring per stage.
// ---------------------------------------------------------------------------
module tac_log2 import tac_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic             in_skip,
  input  logic [VAL_W-1:0] in_val,
  output logic             out_vld,
  output logic             out_skip,
  output logic [LOG_W-1:0] out_log
);

  logic [MANT_W-1:0]   y_r    [0:LOG_FRAC];
  logic [POS_W-1:0]    p_r    [0:LOG_FRAC];
  logic [LOG_FRAC-1:0] frac_r [0:LOG_FRAC];
  logic [LOG_FRAC:0]   vld_r;
  logic [LOG_FRAC:0]   skip_r;

  logic [POS_W-1:0]        pos;
  logic [VAL_W+MANT_W-2:0] shifted;

  // Leading one position and mantissa scaled to Q31.
  always_comb begin
    pos = '0;
    for (int i = 1; i < VAL_W; i++) begin
      if (in_val[i]) pos = POS_W'(i);
    end
    shifted = {in_val, {(MANT_W-1){1'b0}}} >> pos;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r[0]    <= shifted[MANT_W-1:0];
      p_r[0]    <= pos;
      frac_r[0] <= '0;
      skip_r[0] <= in_skip;
    end
  end

  // One squaring of the mantissa per stage yields one fraction bit.
  for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_sq
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     sh;
    logic [MANT_W-1:0]   y_nxt;
    logic [LOG_FRAC-1:0] frac_nxt;

    always_comb begin
      sq       = y_r[k-1] * y_r[k-1];
      sh       = sq[2*MANT_W-1:MANT_W-1];
      frac_nxt = frac_r[k-1];
      if (sh[MANT_W]) begin
        y_nxt                 = sh[MANT_W:1];
        frac_nxt[LOG_FRAC-k]  = 1'b1;
      end else begin
        y_nxt = sh[MANT_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        y_r[k]    <= y_nxt;
        p_r[k]    <= p_r[k-1];
        frac_r[k] <= frac_nxt;
        skip_r[k] <= skip_r[k-1];
      end
    end
  end

  // Valid bits follow the words.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LOG_FRAC-1:0], in_vld};
    end
  end

  assign out_vld  = vld_r[LOG_FRAC];
  assign out_skip = skip_r[LOG_FRAC];
  assign out_log  = {p_r[LOG_FRAC], frac_r[LOG_FRAC]};

endmodule

>>> rtl/tac_div.sv
// ---------------------------------------------------------------------------
// tac_div
// Pipelined restoring divider: one quotient bit per stage, quotient < 2^18.
// ---------------------------------------------------------------------------
module tac_div import tac_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  div_tag_t         in_tag,
  input  logic [N_W-1:0]   in_n,
  input  logic [DEN_W-1:0] in_den,
  output logic             out_vld,
  output div_tag_t         out_tag,
  output logic [Q_W-1:0]   out_q
);

  localparam int CMP_W = N_W + 2;

  logic [N_W-1:0]   r_r   [0:Q_W-1];
  logic [DEN_W-1:0] den_r [0:Q_W-1];
  logic [Q_W-1:0]   q_r   [0:Q_W-1];
  div_tag_t         tag_r [0:Q_W-1];
  logic [Q_W-1:0]   vld_r;

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    localparam int BITPOS = Q_W - 1 - i;
    logic [N_W-1:0]   r_prev;
    logic [DEN_W-1:0] den_prev;
    logic [Q_W-1:0]   q_prev;
    div_tag_t         tag_prev;
    logic [CMP_W-1:0] dsh;
    logic [CMP_W-1:0] diff;
    logic [N_W-1:0]   r_nxt;
    logic [Q_W-1:0]   q_nxt;

    if (i == 0) begin : g_first
      assign r_prev   = in_n;
      assign den_prev = in_den;
      assign q_prev   = '0;
      assign tag_prev = in_tag;
    end else begin : g_rest
      assign r_prev   = r_r[i-1];
      assign den_prev = den_r[i-1];
      assign q_prev   = q_r[i-1];
      assign tag_prev = tag_r[i-1];
    end

    // Trial subtract of the shifted divisor.
    always_comb begin
      dsh   = CMP_W'(den_prev) << BITPOS;
      diff  = CMP_W'(r_prev) - dsh;
      r_nxt = r_prev;
      q_nxt = q_prev;
      if (CMP_W'(r_prev) >= dsh) begin
        r_nxt         = diff[N_W-1:0];
        q_nxt[BITPOS] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[i]   <= r_nxt;
        den_r[i] <= den_prev;
        q_r[i]   <= q_nxt;
        tag_r[i] <= tag_prev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Q_W-2:0], in_vld};
    end
  end

  assign out_vld = vld_r[Q_W-1];
  assign out_tag = tag_r[Q_W-1];
  assign out_q   = q_r[Q_W-1];

endmodule

>>> rtl/thermistor_adc_to_celsius.sv
// ---------------------------------------------------------------------------
// thermistor_adc_to_celsius
// NTC thermistor divider code to temperature in 0.01 degC by the Beta equation.
// ---------------------------------------------------------------------------
// One word enters per clock unless the output stalls, and passes one input
// register, 25 log stages (normalize plus one mantissa squaring per fraction
// bit), six arithmetic stages, 18 divider stages (one quotient bit each) and
// the output register. When the output word is not taken, the whole pipeline
// holds; nothing is dropped.
// Codes at zero or full scale, or a zero resistor setting, give valid_res=0.
// Write configuration only while the pipeline is empty.
module thermistor_adc_to_celsius import tac_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream. in_tdata: [11:0] adc_code.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Result stream. out_tdata: [17:0] temp_centi_celsius.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tuser: [0] valid_res, [1] clipped.
  output logic [OUT_USER_W-1:0] out_tuser,
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

  logic en;

  // Configuration registers.
  logic [BETA_W-1:0] beta_r;
  logic [RES_W-1:0]  fixres_r;
  logic [RES_W-1:0]  nomres_r;
  logic [T0_W-1:0]   t0_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r   <= BETA_RST;
      fixres_r <= FIXED_RES_RST;
      nomres_r <= NOM_RES_RST;
      t0_r     <= NOM_TEMP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BETA:      beta_r   <= cfg_data[BETA_W-1:0];
        REG_FIXED_RES: fixres_r <= cfg_data[RES_W-1:0];
        REG_NOM_RES:   nomres_r <= cfg_data[RES_W-1:0];
        REG_NOM_TEMP:  t0_r     <= cfg_data[T0_W-1:0];
        default:       ;
      endcase
    end
  end

  // The pipeline moves unless a finished word waits at the output.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Stage 1: resistor products and the invalid-code check.
  logic [ADC_BITS-1:0] code;
  logic                s1_vld_r, s1_skip_r;
  logic [VAL_W-1:0]    s1_a_r, s1_b_r;

  assign code = in_tdata[ADC_BITS-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_skip_r <= (code == '0) || (code == FULL_CODE) ||
                   (fixres_r == '0) || (nomres_r == '0);
      s1_a_r    <= VAL_W'(fixres_r) * VAL_W'(code);
      s1_b_r    <= VAL_W'(nomres_r) * VAL_W'(FULL_CODE - code);
    end
  end

  // Log2 of both products.
  logic             la_vld, la_skip, lb_vld, lb_skip;
  logic [LOG_W-1:0] la, lb;

  tac_log2 u_log_a (
    .clk, .rst_n, .en,
    .in_vld(s1_vld_r), .in_skip(s1_skip_r), .in_val(s1_a_r),
    .out_vld(la_vld), .out_skip(la_skip), .out_log(la)
  );

  tac_log2 u_log_b (
    .clk, .rst_n, .en,
    .in_vld(s1_vld_r), .in_skip(s1_skip_r), .in_val(s1_b_r),
    .out_vld(lb_vld), .out_skip(lb_skip), .out_log(lb)
  );

  // Stage 2: magnitude and sign of the log2 difference.
  logic [L_W-1:0]   diff, negd;
  logic             s2_vld_r, s2_skip_r, s2_neg_r;
  logic [LOG_W-1:0] s2_mag_r;

  always_comb begin
    diff = {1'b0, la} - {1'b0, lb};
    negd = L_W'(0) - diff;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_skip_r <= la_skip;
      s2_neg_r  <= diff[L_W-1];
      s2_mag_r  <= diff[L_W-1] ? negd[LOG_W-1:0] : diff[LOG_W-1:0];
    end
  end

  // Stage 3: scale by ln(2).
  logic              s3_vld_r, s3_skip_r, s3_neg_r;
  logic [PROD_W-1:0] s3_prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_skip_r <= s2_skip_r;
      s3_neg_r  <= s2_neg_r;
      s3_prod_r <= PROD_W'(s2_mag_r) * PROD_W'(LN2_Q30);
    end
  end

  // Stage 4: round half up to Q24, then apply the sign.
  logic [PROD_W-1:0] rnd;
  logic [L_W-1:0]    lpos;
  logic              s4_vld_r, s4_skip_r;
  logic [L_W-1:0]    s4_l_r;

  always_comb begin
    rnd  = s3_prod_r + (PROD_W'(1) << (LN2_W - 1));
    lpos = {1'b0, rnd[PROD_W-1:LN2_W]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_skip_r <= s3_skip_r;
      s4_l_r    <= s3_neg_r ? (L_W'(0) - lpos) : lpos;
    end
  end

  // Stage 5: T0 times ln(x), and T0 times beta.
  logic signed [TL_W-1:0] t0_s, l_s;
  logic                   s5_vld_r, s5_skip_r;
  logic [TL_W-1:0]        s5_tl_r;
  logic [BETA_W+T0_W-1:0] s5_tb_r;

  always_comb begin
    t0_s = {{(TL_W-T0_W){1'b0}}, t0_r};
    l_s  = {{(TL_W-L_W){s4_l_r[L_W-1]}}, s4_l_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_skip_r <= s4_skip_r;
      s5_tl_r   <= t0_s * l_s;
      s5_tb_r   <= (BETA_W+T0_W)'(t0_r) * (BETA_W+T0_W)'(beta_r);
    end
  end

  // Stage 6: denominator 100*beta*2^24 + T0*L, numerator base 100*T0*beta.
  logic [B100_W-1:0] b100;
  logic [DENS_W-1:0] bterm, tl_ext;
  logic              s6_vld_r, s6_skip_r;
  logic [DENS_W-1:0] s6_dens_r;
  logic [NB_W-1:0]   s6_nb_r;

  always_comb begin
    b100   = B100_W'(beta_r) * B100_W'(100);
    bterm  = DENS_W'({b100, {LOG_FRAC{1'b0}}});
    tl_ext = {{(DENS_W-TL_W){s5_tl_r[TL_W-1]}}, s5_tl_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_skip_r <= s5_skip_r;
      s6_dens_r <= bterm + tl_ext;
      s6_nb_r   <= NB_W'(s5_tb_r) * NB_W'(100);
    end
  end

  // Stage 7: rounding bias, sign and range checks ahead of the divider.
  logic [DEN_W-1:0] den;
  logic [N_W-1:0]   numr;
  logic             nonpos, ovf;
  logic             s7_vld_r;
  div_tag_t         s7_tag_r;
  logic [N_W-1:0]   s7_n_r;
  logic [DEN_W-1:0] s7_den_r;

  always_comb begin
    den    = s6_dens_r[DEN_W-1:0];
    nonpos = s6_dens_r[DENS_W-1] || (s6_dens_r == '0);
    numr   = N_W'({s6_nb_r, {LOG_FRAC{1'b0}}}) + N_W'(den >> 1);
    ovf    = ({2'b00, numr} >= (N_W+2)'({den, {Q_W{1'b0}}}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_tag_r.skip <= s6_skip_r;
      s7_tag_r.clip <= nonpos || ovf;
      s7_n_r        <= numr;
      s7_den_r      <= den;
    end
  end

  // Valid bits of the arithmetic stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
      s2_vld_r <= la_vld && lb_vld;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
      s7_vld_r <= s6_vld_r;
    end
  end

  // Temperature in centikelvin.
  logic           dv_vld;
  div_tag_t       dv_tag;
  logic [Q_W-1:0] dv_q;

  tac_div u_div (
    .clk, .rst_n, .en,
    .in_vld(s7_vld_r), .in_tag(s7_tag_r), .in_n(s7_n_r), .in_den(s7_den_r),
    .out_vld(dv_vld), .out_tag(dv_tag), .out_q(dv_q)
  );

  // Output register: offset to Celsius and saturate.
  logic              out_vld_r, out_res_r, out_clip_r;
  logic [TEMP_W-1:0] out_temp_r;
  logic [TEMP_W-1:0] temp_nxt;
  logic              res_nxt, clip_nxt;

  always_comb begin
    priority if (dv_tag.skip) begin
      temp_nxt = '0;
      res_nxt  = 1'b0;
      clip_nxt = 1'b0;
    end else if (dv_tag.clip || (dv_q > Q_W'(TCK_MAX))) begin
      temp_nxt = TEMP_W'(TEMP_MAX);
      res_nxt  = 1'b1;
      clip_nxt = 1'b1;
    end else begin
      temp_nxt = TEMP_W'(dv_q) - TEMP_W'(KELVIN_OFFSET);
      res_nxt  = 1'b1;
      clip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_temp_r <= temp_nxt;
      out_res_r  <= res_nxt;
      out_clip_r <= clip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DATA_W'(out_temp_r);
  assign out_tuser  = {out_clip_r, out_res_r};

  // A clipped word is valid and sits at the upper limit.
  `ASSERT_IMPLIES(a_clip_at_max, out_tvalid && out_clip_r,
                  out_res_r && (out_temp_r == TEMP_W'(TEMP_MAX)))
  // A word without a valid result carries zero and no clip.
  `ASSERT_IMPLIES(a_invalid_zero, out_tvalid && !out_res_r,
                  (out_temp_r == '0) && !out_clip_r)
  // Both log lanes stay in step; the skip flags only count on a live word.
  `ASSERT_ALWAYS(a_lanes_aligned, (la_vld == lb_vld) && (!la_vld || (la_skip == lb_skip)))
  // A stall freezes the valid bits on both sides of the log stages.
  `ASSERT_NEXT(a_stall_holds_s1, !en, $stable(s1_vld_r) && $stable(s2_vld_r))

endmodule

>>> test/tb_thermistor_adc_to_celsius.sv
// ---------------------------------------------------------------------------
// tb_thermistor_adc_to_celsius
// Self-checking bench for the thermistor code to temperature pipeline.
// A clocked driver feeds codes from a queue and a clocked monitor compares
// every result word with a fixed-point Beta-equation predictor. The run goes
// through several register settings and several idling phases.
// ---------------------------------------------------------------------------
module tb_thermistor_adc_to_celsius import tac_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 80;
  localparam int WATCHDOG_MAX = 20000;

  typedef struct {
    logic [TEMP_W-1:0] temp;
    logic              ok;
    logic              clip;
  } temp_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow registers of the predictor.
  logic [BETA_W-1:0] beta_q = BETA_RST;
  logic [RES_W-1:0]  rfix_q = FIXED_RES_RST;
  logic [RES_W-1:0]  rnom_q = NOM_RES_RST;
  logic [T0_W-1:0]   t0_q   = NOM_TEMP_RST;

  logic [ADC_BITS-1:0] code_q[$];
  temp_word_t          expected_temps[$];
  int  n_errors = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  watchdog = 0;
  bit  stim_done = 1'b0;

  always #10 clk = ~clk;

  thermistor_adc_to_celsius dut (.*);

  // log2 in Q24 from msb position and repeated mantissa squaring.
  function automatic longint unsigned log2_q24(longint unsigned v);
    int p;
    longint unsigned y, acc;
    p = 0;
    while (p < 63 && (v >> (p + 1)) != 0) p++;
    y = (p >= 31) ? (v >> (p - 31)) : (v << (31 - p));
    acc = longint'(p) << LOG_FRAC;
    for (int i = LOG_FRAC - 1; i >= 0; i--) begin
      y = (y * y) >> 31;
      if (y >= (64'd2 << 31)) begin
        y = y >> 1;
        acc |= 64'd1 << i;
      end
    end
    return acc;
  endfunction

  // Temperature word expected for one converter code.
  function automatic temp_word_t beta_temperature(logic [ADC_BITS-1:0] code);
    temp_word_t w;
    longint unsigned a, b, mag, num, den, tck;
    longint ld, l, dens, t;
    w.ok = 1'b0; w.clip = 1'b0; w.temp = '0;
    if (code == 0 || code == FULL_CODE || rfix_q == 0 || rnom_q == 0) return w;
    a = longint'(rfix_q) * code;
    b = longint'(rnom_q) * (FULL_CODE - code);
    ld = longint'(log2_q24(a)) - longint'(log2_q24(b));
    mag = (ld < 0) ? -ld : ld;
    mag = (mag * 64'(LN2_Q30) + (64'd1 << 29)) >> 30;
    l = (ld < 0) ? -longint'(mag) : longint'(mag);
    dens = longint'((64'd100 * beta_q) << LOG_FRAC) + longint'(t0_q) * l;
    w.ok = 1'b1;
    if (dens <= 0) begin
      t = TEMP_MAX; w.clip = 1'b1;
    end else begin
      den = dens;
      num = (64'd100 * t0_q * beta_q) << LOG_FRAC;
      tck = (num + den / 2) / den;
      if (tck > TCK_MAX) begin
        t = TEMP_MAX; w.clip = 1'b1;
      end else begin
        t = longint'(tck) - KELVIN_OFFSET;
      end
    end
    w.temp = t[TEMP_W-1:0];
    return w;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // Driver: one code per accepted word, random gaps per phase.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (code_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {{(IN_DATA_W-ADC_BITS){1'b0}}, code_q[0]};
          expected_temps.push_back(beta_temperature(code_q[0]));
          void'(code_q.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compare each result word with the oldest expectation.
  always @(posedge clk) begin
    temp_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_temps.size() == 0) begin
        report_mismatch("unexpected word", out_tdata[TEMP_W-1:0], 0);
      end else begin
        w = expected_temps.pop_front();
        if (out_tdata[TEMP_W-1:0] !== w.temp)
          report_mismatch("temp", $signed(out_tdata[TEMP_W-1:0]), $signed(w.temp));
        if (out_tdata[OUT_DATA_W-1:TEMP_W] !== '0)
          report_mismatch("tdata pad", out_tdata[OUT_DATA_W-1:TEMP_W], 0);
        if (out_tuser[0] !== w.ok) report_mismatch("valid_res", out_tuser[0], w.ok);
        if (out_tuser[1] !== w.clip) report_mismatch("clipped", out_tuser[1], w.clip);
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready) || !rst_n || stim_done) begin
      watchdog <= 0;
    end else begin
      watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_MAX) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (code_q.size() != 0 || in_tvalid || expected_temps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BETA:      beta_q = val[BETA_W-1:0];
      REG_FIXED_RES: rfix_q = val;
      REG_NOM_RES:   rnom_q = val;
      REG_NOM_TEMP:  t0_q   = val[T0_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_setting(logic [15:0] b, logic [19:0] rf, logic [19:0] rn,
                              logic [15:0] t0);
    write_reg(REG_BETA, b);
    write_reg(REG_FIXED_RES, rf);
    write_reg(REG_NOM_RES, rn);
    write_reg(REG_NOM_TEMP, t0);
  endtask

  // Directed extremes of the code plus a walking bit.
  task automatic queue_directed();
    code_q.push_back(0);
    code_q.push_back(1);
    code_q.push_back(2);
    code_q.push_back(FULL_CODE - 1);
    code_q.push_back(FULL_CODE);
    code_q.push_back(2048);
    code_q.push_back(2047);
    for (int i = 0; i < ADC_BITS; i++) code_q.push_back(12'(1 << i));
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++)
      code_q.push_back(($urandom_range(9) == 0) ?
                       (($urandom_range(1) != 0) ? FULL_CODE : 12'd0) :
                       12'($urandom_range(4095)));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting, no idling.
    queue_directed();
    queue_random(150);
    wait_drained();

    // Extreme settings: large beta, T0 and fixed resistor with a minimal nominal one, then the reverse.
    load_setting(16'hFFFF, 20'hFFFFF, 20'd1, 16'hFFFF);
    send_idle_pct = 70;
    queue_directed();
    queue_random(150);
    wait_drained();

    load_setting(16'd1, 20'd1, 20'hFFFFF, 16'd1);
    send_idle_pct = 0; recv_stall_pct = 70;
    queue_directed();
    queue_random(150);
    wait_drained();

    // Zero resistor and zero beta / T0 special cases.
    load_setting(16'd0, 20'd0, 20'd10000, 16'd0);
    send_idle_pct = 11; recv_stall_pct = 11;
    queue_random(30);
    wait_drained();
    load_setting(16'd0, 20'd4700, 20'd10000, 16'd0);
    queue_random(30);
    wait_drained();
    load_setting(16'd3435, 20'd10000, 20'd0, 16'd29815);
    queue_random(30);
    wait_drained();

    // Random plausible settings across the idling phases.
    for (int s = 0; s < 6; s++) begin
      load_setting(16'($urandom_range(65535, 1)), 20'($urandom_range(1000000, 1)),
                   20'($urandom_range(1000000, 1)), 16'($urandom_range(65535, 1)));
      send_idle_pct  = (s % 3 == 0) ? 0 : 70;
      recv_stall_pct = (s % 2 == 0) ? 11 : 70;
      queue_random(100);
      wait_drained();
    end

    stim_done = 1'b1;
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
